FILE: hw/rtl/bpgd_pkg.sv
// ----------------------------------------------------------------------------
// bpgd_pkg
// Shared types and constants for the button press gesture detector.
// ----------------------------------------------------------------------------
package bpgd_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned EVENT_W     = 3;
    localparam int unsigned S_TDATA_W   = 40;
    localparam int unsigned M_TDATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_MIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_MAX  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(2800);
    localparam logic [CFG_W-1:0] CLICK_MIN_RST  = CFG_W'(50);
    localparam logic [CFG_W-1:0] CLICK_MAX_RST  = CFG_W'(500);
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = CFG_W'(500);

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_PRESS  = 3'd1,
        EV_LONG   = 3'd2,
        EV_FIRST  = 3'd3,
        EV_DOUBLE = 3'd4,
        EV_OTHER  = 3'd5
    } event_kind_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] click_min_ms;
        logic [CFG_W-1:0] click_max_ms;
        logic [CFG_W-1:0] double_gap_ms;
    } bpgd_cfg_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic        double_click;
        logic        power_up;
    } bpgd_result_t;

endpackage

FILE: hw/rtl/button_press_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_press_gesture_detector
// Long-press power toggle and click / double-click detection on a stream of
// debounced button samples.
// ----------------------------------------------------------------------------
// A sample request passes the input register, then the result register, before it
// becomes a result request. Throughput: one sample per cycle while m_tready does not
// stall the result register, set by the single decision stage between the two registers.
// Reset (aresetn low, synchronous): thresholds return to defaults, button
// reads as pressed, power off, no click pending, both channels empty.
module button_press_gesture_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bpgd_pkg::S_TDATA_W-1:0]     s_tdata,   // [0] pin_high, [32:1] now_ms
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bpgd_pkg::M_TDATA_W-1:0]     m_tdata,   // [0] power_up, [1] double_click,
                                                          // [4:2] event_kind
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpgd_pkg::CFG_W-1:0]         cfg_data
);
    import bpgd_pkg::*;

    bpgd_cfg_t    cfg;
    bpgd_result_t result;

    logic              in_valid_reg;
    logic              in_pin_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    bpgd_result_t      out_result_reg;

    logic out_free;
    logic step_en;

    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-EVENT_W-2){1'b0}}, out_result_reg.event_kind,
                       out_result_reg.double_click, out_result_reg.power_up};

    bpgd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpgd_gesture u_gesture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .pin_high (in_pin_reg),
        .now_ms   (in_now_reg),
        .cfg      (cfg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pin_reg <= s_tdata[0];
            in_now_reg <= s_tdata[TIME_W:1];
        end
        if (step_en) begin
            out_result_reg <= result;
        end
    end

endmodule

FILE: hw/rtl/bpgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpgd_cfg_regs
// Threshold registers written through the configuration request channel.
// ----------------------------------------------------------------------------
module bpgd_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bpgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpgd_pkg::CFG_W-1:0]     cfg_data,
    output bpgd_pkg::bpgd_cfg_t        cfg
);
    import bpgd_pkg::*;

    bpgd_cfg_t cfg_reg;
    bpgd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_LONG_PRESS: cfg_next.long_press_ms = cfg_data;
                REG_CLICK_MIN:  cfg_next.click_min_ms  = cfg_data;
                REG_CLICK_MAX:  cfg_next.click_max_ms  = cfg_data;
                REG_DOUBLE_GAP: cfg_next.double_gap_ms = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms <= LONG_PRESS_RST;
            cfg_reg.click_min_ms  <= CLICK_MIN_RST;
            cfg_reg.click_max_ms  <= CLICK_MAX_RST;
            cfg_reg.double_gap_ms <= DOUBLE_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/bpgd_gesture.sv
// ----------------------------------------------------------------------------
// bpgd_gesture
// Gesture state and the per-sample decision logic.
// ----------------------------------------------------------------------------
module bpgd_gesture (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic                          pin_high,
    input  logic [bpgd_pkg::TIME_W-1:0]   now_ms,
    input  bpgd_pkg::bpgd_cfg_t           cfg,
    output bpgd_pkg::bpgd_result_t        result
);
    import bpgd_pkg::*;

    logic              button_down_reg,   button_down_next;
    logic              power_state_reg,   power_state_next;
    logic [TIME_W-1:0] mark_time_reg,     mark_time_next;
    logic              click_pending_reg, click_pending_next;
    logic              double_flag_reg,   double_flag_next;
    event_kind_t       event_kind;

    logic [TIME_W-1:0] elapsed;
    logic              level_change;
    logic              gap_expired;
    logic              long_hold;
    logic              click_hold;

    assign level_change = (pin_high == button_down_reg);
    assign elapsed      = now_ms - mark_time_reg;
    assign gap_expired  = elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.double_gap_ms};
    assign long_hold    = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};
    assign click_hold   = (elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.click_min_ms})
                       && (elapsed < {{(TIME_W-CFG_W){1'b0}}, cfg.click_max_ms});

    always_comb begin
        button_down_next   = button_down_reg;
        power_state_next   = power_state_reg;
        mark_time_next     = mark_time_reg;
        click_pending_next = click_pending_reg;
        double_flag_next   = double_flag_reg;
        event_kind         = EV_NONE;
        if (level_change) begin
            button_down_next = !pin_high;
            if (!pin_high) begin
                if (click_pending_reg && gap_expired) begin
                    click_pending_next = 1'b0;
                end
                mark_time_next = now_ms;
                event_kind     = EV_PRESS;
            end else begin
                priority if (long_hold) begin
                    mark_time_next   = '0;
                    power_state_next = !power_state_reg;
                    event_kind       = EV_LONG;
                end else if (click_hold && !click_pending_reg) begin
                    click_pending_next = 1'b1;
                    mark_time_next     = now_ms;
                    double_flag_next   = 1'b0;
                    event_kind         = EV_FIRST;
                end else if (click_hold) begin
                    click_pending_next = 1'b0;
                    mark_time_next     = '0;
                    double_flag_next   = 1'b1;
                    event_kind         = EV_DOUBLE;
                end else begin
                    event_kind = EV_OTHER;
                end
            end
        end
    end

    assign result.power_up     = power_state_next;
    assign result.double_click = double_flag_next;
    assign result.event_kind   = event_kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_down_reg   <= 1'b1;
            power_state_reg   <= 1'b0;
            mark_time_reg     <= '0;
            click_pending_reg <= 1'b0;
            double_flag_reg   <= 1'b0;
        end else if (step_en) begin
            button_down_reg   <= button_down_next;
            power_state_reg   <= power_state_next;
            mark_time_reg     <= mark_time_next;
            click_pending_reg <= click_pending_next;
            double_flag_reg   <= double_flag_next;
        end
    end

endmodule

FILE: hw/rtl/bpgd_checker.sv
// ----------------------------------------------------------------------------
// bpgd_checker
// Port-level checks on result ordering and state consistency.
// ----------------------------------------------------------------------------
module bpgd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [bpgd_pkg::M_TDATA_W-1:0]     m_tdata
);
    import bpgd_pkg::*;

    logic              prev_power_reg;
    logic              prev_double_reg;
    logic              out_acc;
    logic [EVENT_W-1:0] kind;

    assign out_acc = m_tvalid && m_tready;
    assign kind    = m_tdata[EVENT_W+1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_power_reg  <= 1'b0;
            prev_double_reg <= 1'b0;
        end else if (out_acc) begin
            prev_power_reg  <= m_tdata[0];
            prev_double_reg <= m_tdata[1];
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result request pending right after reset");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result request changed");

    a_power_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> ((kind == EV_LONG) ? (m_tdata[0] != prev_power_reg)
                                       : (m_tdata[0] == prev_power_reg)))
        else $error("power state changed without a long release");

    a_double_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && (kind == EV_NONE || kind == EV_PRESS || kind == EV_LONG
                    || kind == EV_OTHER) |-> m_tdata[1] == prev_double_reg)
        else $error("double-click flag changed without a click");

    a_click_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && (kind == EV_FIRST || kind == EV_DOUBLE)
            |-> m_tdata[1] == (kind == EV_DOUBLE))
        else $error("double-click flag wrong on click");

endmodule

bind button_press_gesture_detector bpgd_checker u_bpgd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
